// ===== rtl/core/deq_pkg.sv =====
// Shared constants for the double-ended queue: request codes, word width
// and the default ring depth. No dependencies.
package deq_pkg;

   localparam int WORD_W        = 32;
   localparam int REQ_TYPE_W    = 3;
   localparam int DEPTH_DEFAULT = 1024;

   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY      = 3'd4;

endpackage

// ===== rtl/core/deq_ring_ram.sv =====
// Ring storage for the double-ended queue: one write port, one read port
// with registered read data. Uses deq_pkg for the word width.
module deq_ring_ram #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [deq_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [deq_pkg::WORD_W-1:0] rd_data
);

   logic [deq_pkg::WORD_W-1:0] store_mem [DEPTH];
   logic [deq_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the double-ended queue: request decode, head/count pointers,
// cached end words and the result register. Uses deq_pkg and deq_ring_ram.
//
// Each request item yields one result item. Pushes, queries and failed pops
// are answered from registers; a new item is accepted every cycle unless the
// result side stalls. A successful pop that leaves entries behind fetches the
// word that becomes the new front (or back) through the single read port of
// the ring RAM, whose data is registered, and the request side is held while
// it is fetched. The front and back words are kept in registers, so no other
// request reads the RAM. The RAM needs no clearing after reset; only written
// entries are read. A request code outside the five defined ones is a query.
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // push_value[31:0]
   input  logic [deq_pkg::WORD_W-1:0]                  req_tdata,
   // req_type[2:0]
   input  logic [deq_pkg::REQ_TYPE_W-1:0]              req_tuser,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // popped_value[31:0], pop_failed, push_dropped, entry_count[CW-1:0],
   // is_empty, front_value[31:0], back_value[31:0], zero fill
   output logic [((3*deq_pkg::WORD_W+3+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = CW + 1;
   localparam int WW    = deq_pkg::WORD_W;
   localparam int OUT_W = ((3 * WW + 3 + CW + 7) / 8) * 8;

   function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
      logic [SW-1:0] d;
      d = s - SW'(DEPTH);
      return (s >= SW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
   endfunction

   // Pointer and cache state.
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [WW-1:0] front_ff, front_in;
   logic [WW-1:0] back_ff, back_in;
   logic          pend_ff, pend_in;
   logic          pend_front_ff, pend_front_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] rsp_popped_ff, rsp_popped_in;
   logic          rsp_pop_fail_ff, rsp_pop_fail_in;
   logic          rsp_drop_ff, rsp_drop_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic [WW-1:0] rsp_front_ff, rsp_front_in;
   logic [WW-1:0] rsp_back_ff, rsp_back_in;

   logic          accept;
   logic          is_empty_now, is_full;
   logic          do_push_front, do_push_back, do_pop_front, do_pop_back;
   logic          need_read;
   logic [AW-1:0] head_dec, head_inc;
   logic [SW-1:0] head_plus_count;
   logic [AW-1:0] tail_next, tail_prev;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [WW-1:0] rd_data;

   assign req_tready = !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_empty_now    = (count_ff == '0);
   assign is_full         = (count_ff == CW'(DEPTH));
   assign head_dec        = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc        = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_plus_count = SW'(head_ff) + SW'(count_ff);
   assign tail_next       = wrap_idx(head_plus_count);
   // Only used when at least two entries are live.
   assign tail_prev       = wrap_idx(head_plus_count - SW'(2));

   always_comb begin
      do_push_front = 1'b0;
      do_push_back  = 1'b0;
      do_pop_front  = 1'b0;
      do_pop_back   = 1'b0;
      unique case (req_tuser)
         deq_pkg::REQ_PUSH_FRONT: do_push_front = !is_full;
         deq_pkg::REQ_PUSH_BACK:  do_push_back  = !is_full;
         deq_pkg::REQ_POP_FRONT:  do_pop_front  = !is_empty_now;
         deq_pkg::REQ_POP_BACK:   do_pop_back   = !is_empty_now;
         default: ;
      endcase
   end

   // A pop that leaves entries must fetch the new end word from the RAM.
   assign need_read = (do_pop_front || do_pop_back) && (count_ff != CW'(1));

   assign wr_en   = accept && (do_push_front || do_push_back);
   assign wr_addr = do_push_front ? head_dec : tail_next;
   assign rd_addr = do_pop_front ? head_inc : tail_prev;

   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      front_in        = front_ff;
      back_in         = back_ff;
      pend_in         = 1'b0;
      pend_front_in   = pend_front_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_popped_in   = rsp_popped_ff;
      rsp_pop_fail_in = rsp_pop_fail_ff;
      rsp_drop_in     = rsp_drop_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_front_in    = rsp_front_ff;
      rsp_back_in     = rsp_back_ff;

      if (accept) begin
         if (do_push_front) begin
            head_in  = head_dec;
            count_in = count_ff + 1'b1;
            front_in = req_tdata;
            if (is_empty_now) begin
               back_in = req_tdata;
            end
         end else if (do_push_back) begin
            count_in = count_ff + 1'b1;
            back_in  = req_tdata;
            if (is_empty_now) begin
               front_in = req_tdata;
            end
         end else if (do_pop_front) begin
            head_in  = head_inc;
            count_in = count_ff - 1'b1;
         end else if (do_pop_back) begin
            count_in = count_ff - 1'b1;
         end

         pend_in         = need_read;
         pend_front_in   = do_pop_front;
         rsp_valid_in    = !need_read;
         rsp_popped_in   = do_pop_front ? front_ff : (do_pop_back ? back_ff : '0);
         rsp_pop_fail_in = ((req_tuser == deq_pkg::REQ_POP_FRONT) ||
                            (req_tuser == deq_pkg::REQ_POP_BACK)) && is_empty_now;
         rsp_drop_in     = ((req_tuser == deq_pkg::REQ_PUSH_FRONT) ||
                            (req_tuser == deq_pkg::REQ_PUSH_BACK)) && is_full;
         rsp_count_in    = count_in;
         rsp_front_in    = (count_in == '0) ? '0 : front_in;
         rsp_back_in     = (count_in == '0) ? '0 : back_in;
      end else if (pend_ff) begin
         // The fetched word replaces the end that was popped.
         rsp_valid_in = 1'b1;
         if (pend_front_ff) begin
            front_in     = rd_data;
            rsp_front_in = rd_data;
         end else begin
            back_in     = rd_data;
            rsp_back_in = rd_data;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff        <= front_in;
      back_ff         <= back_in;
      pend_front_ff   <= pend_front_in;
      rsp_popped_ff   <= rsp_popped_in;
      rsp_pop_fail_ff <= rsp_pop_fail_in;
      rsp_drop_ff     <= rsp_drop_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_front_ff    <= rsp_front_in;
      rsp_back_ff     <= rsp_back_in;
   end

   deq_ring_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (accept && need_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_back_ff, rsp_front_ff, (rsp_count_ff == '0),
                               rsp_count_ff, rsp_drop_ff, rsp_pop_fail_ff,
                               rsp_popped_ff});

endmodule

// ===== rtl/core/deq_checker.sv =====
// Port-level checks for the double-ended queue and the bind that attaches
// them to the top level. Uses deq_pkg for the word width.
module deq_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_tvalid,
   input logic                                        req_tready,
   input logic                                        rsp_tvalid,
   input logic                                        rsp_tready,
   input logic [((3*deq_pkg::WORD_W+3+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int CW  = $clog2(DEPTH + 1);
   localparam int WW  = deq_pkg::WORD_W;
   localparam int CLO = WW + 2;

   logic [CW-1:0] count_f;
   logic          empty_f;
   logic [WW-1:0] front_f;
   logic [WW-1:0] back_f;

   assign count_f = rsp_tdata[CLO+CW-1:CLO];
   assign empty_f = rsp_tdata[CLO+CW];
   assign front_f = rsp_tdata[CLO+CW+WW:CLO+CW+1];
   assign back_f  = rsp_tdata[CLO+CW+2*WW:CLO+CW+WW+1];

   // A held result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The empty flag agrees with the reported count.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (empty_f == (count_f == '0)))
      else $error("empty flag disagrees with count");

   // An empty queue shows zero end words.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && empty_f |-> (front_f == '0) && (back_f == '0))
      else $error("end words not zero on empty queue");

   // A request item accepted while the result side was empty shows up as a
   // result, even when the pop must fetch a word from the RAM.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 (rsp_tvalid || $past(rsp_tvalid)))
      else $error("result did not appear in time");

   // The count never exceeds the depth.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (count_f <= CW'(DEPTH)))
      else $error("count exceeds depth");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed table, then random push/pop traffic
// scored against a behavioral deque kept in the testbench. Depends on deq_pkg and the RTL.
module tb_double_ended_queue;

   localparam int WORD_W       = deq_pkg::WORD_W;
   localparam int REQ_TYPE_W   = deq_pkg::REQ_TYPE_W;
   localparam int DEPTH        = deq_pkg::DEPTH_DEFAULT;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int COUNT_W      = $clog2(DEPTH + 1);
   localparam int RSP_W        = ((3 * WORD_W + 3 + COUNT_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ROW_COUNT    = 24;

   // Request codes with no defined action; the block treats them as queries.
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_5 = 3'd5;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

   // Result fields, declared from the top bit down to match rsp_tdata.
   typedef struct packed {
      logic [WORD_W-1:0]  back_word;
      logic [WORD_W-1:0]  front_word;
      logic               empty;
      logic [COUNT_W-1:0] count;
      logic               dropped;
      logic               failed;
      logic [WORD_W-1:0]  popped;
   } deq_result_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0] kind;
      logic [WORD_W-1:0]     word;
      bit                    typed;
      deq_result_type        want;
   } deq_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata;
   logic [REQ_TYPE_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;

   // Behavioral copy of the deque state.
   logic [WORD_W-1:0] ring_model [DEPTH];
   int                model_head;
   int                model_count;

   deq_result_type pending_results [$];
   deq_row_type    directed_rows [ROW_COUNT];

   int error_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int drops_seen    = 0;
   int empty_pops    = 0;
   int peak_count    = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_started  = 1'b0;

   double_ended_queue #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic deq_result_type result_of(input logic [WORD_W-1:0] popped,
                                                input int failed, input int dropped,
                                                input int count,
                                                input logic [WORD_W-1:0] front_word,
                                                input logic [WORD_W-1:0] back_word);
      deq_result_type res;
      res.popped     = popped;
      res.failed     = (failed != 0);
      res.dropped    = (dropped != 0);
      res.count      = COUNT_W'(count);
      res.empty      = (count == 0);
      res.front_word = front_word;
      res.back_word  = back_word;
      return res;
   endfunction

   // Ring position of a logical offset from slot zero.
   function automatic logic [ADDR_W-1:0] slot(input int pos);
      return ADDR_W'(pos % DEPTH);
   endfunction

   // Applies one request to the behavioral deque and returns the result it must give.
   function automatic deq_result_type deque_step(input logic [REQ_TYPE_W-1:0] kind,
                                                 input logic [WORD_W-1:0] word);
      deq_result_type res;
      res = '0;
      case (kind) inside
         deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
            if (model_count == DEPTH) begin
               res.dropped = 1'b1;
               drops_seen++;
            end else if (kind == deq_pkg::REQ_PUSH_FRONT) begin
               model_head = (model_head + DEPTH - 1) % DEPTH;
               ring_model[slot(model_head)] = word;
               model_count++;
            end else begin
               ring_model[slot(model_head + model_count)] = word;
               model_count++;
            end
         end
         deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
            if (model_count == 0) begin
               res.failed = 1'b1;
               empty_pops++;
            end else if (kind == deq_pkg::REQ_POP_FRONT) begin
               res.popped = ring_model[slot(model_head)];
               model_head = (model_head + 1) % DEPTH;
               model_count--;
            end else begin
               res.popped = ring_model[slot(model_head + model_count - 1)];
               model_count--;
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(model_count);
      res.empty = (model_count == 0);
      if (model_count != 0) begin
         res.front_word = ring_model[slot(model_head)];
         res.back_word  = ring_model[slot(model_head + model_count - 1)];
      end
      if (model_count > peak_count) peak_count = model_count;
      return res;
   endfunction

   function automatic bit quiet_window();
      return (cycle_count >= 3000) && (cycle_count < 5000);
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] pick_kind(input int push_pct, input int pop_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_pct)
         return ($urandom_range(1) != 0) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
      if (roll < push_pct + pop_pct)
         return ($urandom_range(1) != 0) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
      case ($urandom_range(3))
         0: return REQ_SPARE_5;
         1: return REQ_SPARE_6;
         2: return REQ_SPARE_7;
         default: return deq_pkg::REQ_QUERY;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Offers one item, waits for the handshake and records what it must produce.
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input logic [WORD_W-1:0] word,
                               input bit typed, input deq_result_type want);
      deq_result_type model;
      while (!quiet_window() && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         req_tuser  <= REQ_TYPE_W'($urandom());
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = deque_step(kind, word);
      pending_results.insert(pending_results.size(), typed ? want : model);
      items_sent++;
   endtask

   task automatic send_random(input int push_pct, input int pop_pct);
      send_request(pick_kind(push_pct, pop_pct), pick_word(), 1'b0, '0);
   endtask

   task automatic check_result(input deq_result_type got, input deq_result_type want);
      if (got.popped !== want.popped) begin
         $error("popped_value: expected %0d, got %0d", $signed(want.popped), $signed(got.popped));
         error_count++;
      end
      if (got.failed !== want.failed) begin
         $error("pop_failed: expected %0d, got %0d", want.failed, got.failed);
         error_count++;
      end
      if (got.dropped !== want.dropped) begin
         $error("push_dropped: expected %0d, got %0d", want.dropped, got.dropped);
         error_count++;
      end
      if (got.count !== want.count) begin
         $error("entry_count: expected %0d, got %0d", want.count, got.count);
         error_count++;
      end
      if (got.empty !== want.empty) begin
         $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
         error_count++;
      end
      if (got.front_word !== want.front_word) begin
         $error("front_value: expected %0d, got %0d", $signed(want.front_word),
                $signed(got.front_word));
         error_count++;
      end
      if (got.back_word !== want.back_word) begin
         $error("back_value: expected %0d, got %0d", $signed(want.back_word),
                $signed(got.back_word));
         error_count++;
      end
   endtask

   // Result side: cycle count, timeout, scoring and the ready pattern.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result item arrived with no request outstanding");
               error_count++;
            end else begin
               check_result(deq_result_type'(rsp_tdata[$bits(deq_result_type)-1:0]),
                            pending_results[0]);
               pending_results.delete(0);
            end
         end
         // One long hold-off so the result register backs up and stalls requests.
         if (!hold_started && items_sent >= 500) begin
            hold_started = 1'b1;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet_window()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 20);
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = deq_pkg::REQ_QUERY;
      rsp_tready = 1'b0;
      model_head  = 0;
      model_count = 0;

      directed_rows[0]  = '{deq_pkg::REQ_QUERY,      32'h0,         1'b1,
                            result_of(0, 0, 0, 0, 0, 0)};
      directed_rows[1]  = '{deq_pkg::REQ_POP_FRONT,  32'h0,         1'b1,
                            result_of(0, 1, 0, 0, 0, 0)};
      directed_rows[2]  = '{deq_pkg::REQ_POP_BACK,   32'hFFFF_FFFF, 1'b1,
                            result_of(0, 1, 0, 0, 0, 0)};
      directed_rows[3]  = '{deq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
                            result_of(0, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
      directed_rows[4]  = '{deq_pkg::REQ_PUSH_BACK,  32'h8000_0000, 1'b1,
                            result_of(0, 0, 0, 2, 32'h7FFF_FFFF, 32'h8000_0000)};
      directed_rows[5]  = '{deq_pkg::REQ_PUSH_FRONT, 32'h0000_0000, 1'b0, '0};
      directed_rows[6]  = '{deq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0};
      directed_rows[7]  = '{REQ_SPARE_5,             32'hAAAA_AAAA, 1'b0, '0};
      directed_rows[8]  = '{REQ_SPARE_6,             32'h5555_5555, 1'b0, '0};
      directed_rows[9]  = '{REQ_SPARE_7,             32'hFFFF_FFFF, 1'b0, '0};
      directed_rows[10] = '{deq_pkg::REQ_QUERY,      32'h1234_5678, 1'b0, '0};
      directed_rows[11] = '{deq_pkg::REQ_POP_FRONT,  32'h0,         1'b0, '0};
      directed_rows[12] = '{deq_pkg::REQ_POP_BACK,   32'h0,         1'b0, '0};
      directed_rows[13] = '{deq_pkg::REQ_PUSH_BACK,  32'h0000_0001, 1'b0, '0};
      directed_rows[14] = '{deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b0, '0};
      directed_rows[15] = '{deq_pkg::REQ_POP_FRONT,  32'h0,         1'b0, '0};
      directed_rows[16] = '{deq_pkg::REQ_POP_FRONT,  32'h0,         1'b0, '0};
      directed_rows[17] = '{deq_pkg::REQ_POP_BACK,   32'h0,         1'b0, '0};
      directed_rows[18] = '{deq_pkg::REQ_POP_BACK,   32'h0,         1'b0, '0};
      directed_rows[19] = '{deq_pkg::REQ_POP_FRONT,  32'h0,         1'b1,
                            result_of(0, 1, 0, 0, 0, 0)};
      directed_rows[20] = '{deq_pkg::REQ_PUSH_BACK,  32'h1234_5678, 1'b1,
                            result_of(0, 0, 0, 1, 32'h1234_5678, 32'h1234_5678)};
      directed_rows[21] = '{deq_pkg::REQ_POP_FRONT,  32'h0,         1'b1,
                            result_of(32'h1234_5678, 0, 0, 0, 0, 0)};
      directed_rows[22] = '{deq_pkg::REQ_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '0};
      directed_rows[23] = '{deq_pkg::REQ_POP_BACK,   32'h0,         1'b0, '0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].typed,
                      directed_rows[i].want);

      // Mixed traffic near empty, then fill to the top, bounce off the full
      // queue, drain part of it and finish with balanced traffic.
      repeat (150) send_random(40, 45);
      while (model_count < DEPTH) send_random(95, 3);
      repeat (60) send_random(60, 25);
      repeat (550) send_random(5, 90);
      repeat (60) send_random(45, 45);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d results; the queue peaked at %0d of %0d.",
               items_sent, results_seen, peak_count, DEPTH);
      $display("Seen %0d pushes dropped on a full queue and %0d pops on an empty one.",
               drops_seen, empty_pops);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
